// File: hw/rtl/pss_pkg.sv
package pss_pkg;

    // default table depth and register reset value
    localparam int ENTRIES_DEF = 16;
    localparam logic [7:0] TICK_STEP_RST = 8'd10;

    // set status codes
    localparam logic [2:0] ST_TICK    = 3'd0;
    localparam logic [2:0] ST_UPDATED = 3'd1;
    localparam logic [2:0] ST_REMOVED = 3'd2;
    localparam logic [2:0] ST_ADDED   = 3'd3;
    localparam logic [2:0] ST_NONE    = 3'd4;

    // request function codes
    localparam logic FUNC_TICK = 1'b0;

    // input request
    typedef struct packed {
        logic        func;
        logic [15:0] var_id;
        logic [15:0] period;
    } t_in_item;

    // result item
    typedef struct packed {
        logic        send_valid;
        logic [15:0] send_var_id;
        logic [2:0]  set_status;
    } t_out_item;

    // one stream entry
    typedef struct packed {
        logic        en;
        logic [15:0] var_id;
        logic [15:0] period;
        logic [15:0] timer;
    } t_entry;

    // what the head cell does in the current pass
    typedef enum logic [2:0] {
        MODE_TICK  = 3'b001,
        MODE_MATCH = 3'b010,
        MODE_FILL  = 3'b100
    } t_mode;

    // control group from the sequencer to the head logic
    typedef struct packed {
        t_mode       mode;
        logic        done;
        logic [7:0]  step;
        logic [15:0] var_id;
        logic [15:0] period;
    } t_head_req;

endpackage

// File: hw/rtl/pss_cell.sv
module pss_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  pss_pkg::t_entry i_entry,
    output pss_pkg::t_entry o_entry
);

    pss_pkg::t_entry r_entry;

    // entry storage, takes the neighbor's entry on every shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

// File: hw/rtl/pss_head.sv
module pss_head (
    input  pss_pkg::t_head_req i_req,
    input  pss_pkg::t_entry    i_entry,
    output pss_pkg::t_entry    o_entry,
    output logic               o_hit
);

    logic [15:0] w_sum;

    // timer advanced by the tick step, 16-bit wrap
    assign w_sum = i_entry.timer + {8'd0, i_req.step};

    // update of the entry passing the head of the ring
    always_comb begin
        o_entry = i_entry;
        o_hit   = 1'b0;
        unique case (i_req.mode)
            pss_pkg::MODE_TICK: begin
                o_entry.timer = w_sum;
                if (!i_req.done && i_entry.en && (i_entry.period != 16'd0) &&
                    (w_sum >= i_entry.period)) begin
                    o_entry.timer = 16'd0;
                    o_hit         = 1'b1;
                end
            end
            pss_pkg::MODE_MATCH: begin
                if (i_entry.var_id == i_req.var_id) begin
                    if (i_req.period != 16'd0) begin
                        // first match only is updated
                        if (!i_req.done) begin
                            o_entry.period = i_req.period;
                            o_entry.en     = 1'b1;
                            o_hit          = 1'b1;
                        end
                    end else begin
                        // removal hits every match
                        o_entry.period = 16'd0;
                        o_entry.en     = 1'b0;
                        o_hit          = 1'b1;
                    end
                end
            end
            pss_pkg::MODE_FILL: begin
                if (!i_req.done && !i_entry.en) begin
                    o_entry.var_id = i_req.var_id;
                    o_entry.period = i_req.period;
                    o_entry.en     = 1'b1;
                    o_hit          = 1'b1;
                end
            end
            default: begin
                o_entry = i_entry;
            end
        endcase
    end

endmodule

// File: hw/rtl/periodic_stream_scheduler_core.sv
// channel    | direction | handshake                | payload
// request    | in        | i_in_valid / o_in_stall  | i_in_data  (func, var_id, period)
// result     | out       | o_out_valid / i_out_stall| o_out_data (send_valid, send_var_id,
//            |           |                          |             set_status)
// config     | in        | i_cfg_we                 | i_cfg_wdata (tick_step)
//
// A request is taken, then the ring of ENTRIES cells rotates once, one entry
// through the head logic per cycle. A set with a nonzero period that matches
// nothing rotates the ring twice.
// The result sits in an output register; the next request is taken while it waits.
// A stalled result only delays the end of the following request.
// Synchronous active-low reset clears all entries and sets tick_step to 10.
module periodic_stream_scheduler_core #(
    parameter int ENTRIES = pss_pkg::ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pss_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pss_pkg::t_out_item o_out_data
);

    localparam int CntW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state             r_state, n_state;
    pss_pkg::t_mode     r_mode, n_mode;
    logic [CntW-1:0]    r_cnt, n_cnt;
    logic               r_hit, n_hit;
    logic [15:0]        r_send_id, n_send_id;
    logic [15:0]        r_id, n_id;
    logic [15:0]        r_per, n_per;
    logic [7:0]         r_step;
    logic               r_out_valid, n_out_valid;
    pss_pkg::t_out_item r_out_data, n_out_data;

    pss_pkg::t_entry    w_cell [ENTRIES];
    pss_pkg::t_entry    w_head_out;
    pss_pkg::t_head_req w_head_req;
    pss_pkg::t_out_item w_res;
    logic               w_hit;
    logic               w_shift;
    logic               w_last;
    logic               w_in_acc;
    logic               w_out_free;

    assign w_shift    = (r_state == S_SCAN);
    assign w_last     = (r_cnt == CntW'(ENTRIES - 1));
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // ring of entry cells, the last cell takes the processed head entry
    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        if (k == ENTRIES - 1) begin : g_tail
            pss_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_entry (w_head_out),
                .o_entry (w_cell[k])
            );
        end else begin : g_mid
            pss_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_entry (w_cell[k+1]),
                .o_entry (w_cell[k])
            );
        end
    end

    // head logic
    assign w_head_req.mode   = r_mode;
    assign w_head_req.done   = r_hit;
    assign w_head_req.step   = r_step;
    assign w_head_req.var_id = r_id;
    assign w_head_req.period = r_per;

    pss_head u_head (
        .i_req   (w_head_req),
        .i_entry (w_cell[0]),
        .o_entry (w_head_out),
        .o_hit   (w_hit)
    );

    // result of the finished request
    always_comb begin
        w_res = '0;
        unique case (r_mode)
            pss_pkg::MODE_TICK: begin
                w_res.send_valid  = r_hit;
                w_res.send_var_id = r_send_id;
                w_res.set_status  = pss_pkg::ST_TICK;
            end
            pss_pkg::MODE_MATCH: begin
                if (r_per != 16'd0) begin
                    w_res.set_status = pss_pkg::ST_UPDATED;
                end else begin
                    w_res.set_status = r_hit ? pss_pkg::ST_REMOVED : pss_pkg::ST_NONE;
                end
            end
            pss_pkg::MODE_FILL: begin
                w_res.set_status = r_hit ? pss_pkg::ST_ADDED : pss_pkg::ST_NONE;
            end
            default: begin
                w_res = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_cnt       = r_cnt;
        n_hit       = r_hit;
        n_send_id   = r_send_id;
        n_id        = r_id;
        n_per       = r_per;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state   = S_SCAN;
                    n_mode    = (i_in_data.func == pss_pkg::FUNC_TICK) ?
                                pss_pkg::MODE_TICK : pss_pkg::MODE_MATCH;
                    n_cnt     = '0;
                    n_hit     = 1'b0;
                    n_send_id = 16'd0;
                    n_id      = i_in_data.var_id;
                    n_per     = i_in_data.period;
                end
            end
            S_SCAN: begin
                n_hit = r_hit || w_hit;
                if ((r_mode == pss_pkg::MODE_TICK) && w_hit) begin
                    n_send_id = w_cell[0].var_id;
                end
                n_cnt = r_cnt + CntW'(1);
                if (w_last) begin
                    n_cnt = '0;
                    if ((r_mode == pss_pkg::MODE_MATCH) && (r_per != 16'd0) &&
                        !(r_hit || w_hit)) begin
                        // no match: second pass fills the first free slot
                        n_mode = pss_pkg::MODE_FILL;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = w_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and data registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= pss_pkg::MODE_TICK;
            r_cnt       <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= pss_pkg::TICK_STEP_RST;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_cnt       <= n_cnt;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_send_id  <= n_send_id;
        r_id       <= n_id;
        r_per      <= n_per;
        r_out_data <= n_out_data;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTH
    // an accepted request starts a pass at the head entry
    a_start_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_SCAN) && (r_cnt == '0))
        else $error("request did not start a scan");

    // only a tick result may carry a send
    a_send_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.send_valid) |-> (o_out_data.set_status == pss_pkg::ST_TICK))
        else $error("send flagged on a set result");

    // fill pass only follows a set with a nonzero period and no match
    a_fill_per: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == pss_pkg::MODE_FILL) |-> (r_per != 16'd0))
        else $error("fill pass with zero period");

    // a finished result waits while the output register is blocked
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && r_out_valid && i_out_stall) |=> (r_state == S_DONE))
        else $error("result overwrote a blocked output");

    // no request is taken while the ring rotates
    a_no_idle_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> o_in_stall)
        else $error("request taken during a scan");
`endif

endmodule

// File: tb/tb_top.sv
module tb_top;

    localparam int N_ENTRIES = pss_pkg::ENTRIES_DEF;
    localparam logic FUNC_SET = 1'b1;
    localparam int N_PHASES = 6;
    localparam int PHASE_REQS = 150;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_AT = 230;
    localparam int HOLD_LEN = 400;
    localparam int IDLE_LIMIT = 3000;
    localparam int POOL_SIZE = 20;

    // clock, reset and block ports
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [7:0]         cfg_wdata = 8'd0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    pss_pkg::t_in_item  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    pss_pkg::t_out_item out_data;

    // shadow copy of the stream table and the tick step
    logic        tbl_en     [N_ENTRIES];
    logic [15:0] tbl_id     [N_ENTRIES];
    logic [15:0] tbl_period [N_ENTRIES];
    logic [15:0] tbl_timer  [N_ENTRIES];
    logic [7:0]  cur_step = pss_pkg::TICK_STEP_RST;

    // pending requests and predicted results
    pss_pkg::t_in_item  req_pending_q [$];
    pss_pkg::t_out_item sched_result_q [$];

    logic [15:0] id_pool [POOL_SIZE];
    logic send_gaps = 1'b1;
    logic recv_gaps = 1'b1;
    int   req_accepted = 0;
    int   results_seen = 0;
    int   err_count = 0;
    int   idle_cycles = 0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   hold_left = 0;

    periodic_stream_scheduler_core #(
        .ENTRIES (N_ENTRIES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // apply one request to the shadow table and return the scheduling result
    function automatic pss_pkg::t_out_item stream_table_step(pss_pkg::t_in_item r);
        pss_pkg::t_out_item res;
        logic hit;
        int i;
        res = '0;
        hit = 1'b0;
        if (r.func == pss_pkg::FUNC_TICK) begin
            res.set_status = pss_pkg::ST_TICK;
            for (i = 0; i < N_ENTRIES; i++)
                tbl_timer[i] = tbl_timer[i] + 16'(cur_step);
            // lowest due entry wins, one per tick
            for (i = 0; i < N_ENTRIES; i++) begin
                if (tbl_en[i] && tbl_period[i] != 16'd0 && tbl_timer[i] >= tbl_period[i]) begin
                    res.send_valid = 1'b1;
                    res.send_var_id = tbl_id[i];
                    tbl_timer[i] = 16'd0;
                    return res;
                end
            end
            return res;
        end
        // match pass: update first match, or disable every match
        for (i = 0; i < N_ENTRIES; i++) begin
            if (tbl_id[i] == r.var_id) begin
                if (r.period != 16'd0) begin
                    tbl_period[i] = r.period;
                    tbl_en[i] = 1'b1;
                    res.set_status = pss_pkg::ST_UPDATED;
                    return res;
                end
                tbl_period[i] = 16'd0;
                tbl_en[i] = 1'b0;
                hit = 1'b1;
            end
        end
        if (r.period == 16'd0) begin
            res.set_status = hit ? pss_pkg::ST_REMOVED : pss_pkg::ST_NONE;
            return res;
        end
        // fill pass: first disabled slot, timer kept
        for (i = 0; i < N_ENTRIES; i++) begin
            if (!tbl_en[i]) begin
                tbl_id[i] = r.var_id;
                tbl_period[i] = r.period;
                tbl_en[i] = 1'b1;
                res.set_status = pss_pkg::ST_ADDED;
                return res;
            end
        end
        res.set_status = pss_pkg::ST_NONE;
        return res;
    endfunction

    // random request: mostly ticks and sets on a small id pool
    function automatic pss_pkg::t_in_item rand_request();
        pss_pkg::t_in_item r;
        int pick;
        r.func = ($urandom_range(0, 99) < 55) ? pss_pkg::FUNC_TICK : FUNC_SET;
        r.var_id = 16'($urandom);
        r.period = 16'($urandom);
        if (r.func == FUNC_SET) begin
            if ($urandom_range(0, 99) < 85)
                r.var_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            pick = $urandom_range(0, 99);
            if (pick < 12)
                r.period = 16'd0;
            else if (pick < 15)
                r.period = 16'hFFFF;
            else if (pick >= 23)
                r.period = 16'($urandom_range(1, 400));
        end
        return r;
    endfunction

    task automatic push_req(input logic func, input logic [15:0] id, input logic [15:0] per);
        pss_pkg::t_in_item r;
        r.func = func;
        r.var_id = id;
        r.period = per;
        req_pending_q.push_back(r);
    endtask

    // wait for the block to go quiet
    task automatic wait_idle();
        while (req_pending_q.size() != 0 || in_valid || sched_result_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                sched_result_q.push_back(stream_table_step(in_data));
                req_accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (req_pending_q.size() != 0) begin
                    in_valid <= 1'b1;
                    in_data <= req_pending_q.pop_front();
                    gap_left <= send_gaps ? $urandom_range(0, 19) : 0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with per-result stall and one long hold-off
    always @(posedge i_clk) begin : rx_side
        pss_pkg::t_out_item want;
        int n;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
        end else if (out_valid && !out_stall) begin
            if (sched_result_q.size() == 0) begin
                $error("unexpected result send_valid=%0d send_var_id=%0h set_status=%0d",
                       out_data.send_valid, out_data.send_var_id, out_data.set_status);
                err_count++;
            end else begin
                want = sched_result_q.pop_front();
                if (out_data.send_valid !== want.send_valid) begin
                    $error("send_valid expected %0d actual %0d",
                           want.send_valid, out_data.send_valid);
                    err_count++;
                end
                if (out_data.send_var_id !== want.send_var_id) begin
                    $error("send_var_id expected %0h actual %0h",
                           want.send_var_id, out_data.send_var_id);
                    err_count++;
                end
                if (out_data.set_status !== want.set_status) begin
                    $error("set_status expected %0d actual %0d",
                           want.set_status, out_data.set_status);
                    err_count++;
                end
            end
            results_seen++;
            n = recv_gaps ? $urandom_range(0, 19) : 0;
            stall_left <= n;
            if (results_seen == HOLD_AT) begin
                hold_left <= HOLD_LEN;
                out_stall <= 1'b1;
            end else begin
                out_stall <= (n != 0);
            end
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (out_valid && stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= (stall_left > 1);
        end else begin
            out_stall <= (stall_left != 0);
        end
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // stimulus and phase control
    initial begin : stimulus
        logic [7:0] step_plan [N_PHASES];
        int p;
        int k;
        for (k = 0; k < N_ENTRIES; k++) begin
            tbl_en[k] = 1'b0;
            tbl_id[k] = 16'd0;
            tbl_period[k] = 16'd0;
            tbl_timer[k] = 16'd0;
        end
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (k = 2; k < POOL_SIZE; k++)
            id_pool[k] = 16'($urandom);
        step_plan[0] = 8'd255;
        step_plan[1] = 8'd1;
        step_plan[2] = 8'd0;
        step_plan[3] = 8'($urandom_range(2, 254));
        step_plan[4] = 8'd128;
        step_plan[5] = pss_pkg::TICK_STEP_RST;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty tick, id 0 on cleared slots, no match, fill to full
        @(negedge i_clk);
        push_req(pss_pkg::FUNC_TICK, 16'hFFFF, 16'hFFFF);
        push_req(FUNC_SET, 16'h0000, 16'h0000);
        push_req(FUNC_SET, 16'hFFFF, 16'h0000);
        push_req(FUNC_SET, 16'h0000, 16'h0005);
        push_req(FUNC_SET, 16'hFFFF, 16'hFFFF);
        push_req(pss_pkg::FUNC_TICK, 16'h0000, 16'h0000);
        for (k = 0; k < 15; k++)
            push_req(FUNC_SET, 16'h0100 + 16'(k), 16'h0001);
        push_req(FUNC_SET, 16'hFFFF, 16'h0000);
        push_req(pss_pkg::FUNC_TICK, 16'h0000, 16'h0000);
        push_req(FUNC_SET, 16'h0000, 16'h0000);
        push_req(pss_pkg::FUNC_TICK, 16'h0000, 16'h0000);
        wait_idle();

        // random phases, one tick step each
        for (p = 0; p < N_PHASES; p++) begin
            @(posedge i_clk);
            cfg_we <= 1'b1;
            cfg_wdata <= step_plan[p];
            cur_step = step_plan[p];
            send_gaps <= (p != 1 && p != 4);
            recv_gaps <= (p != 2 && p != 4);
            @(posedge i_clk);
            cfg_we <= 1'b0;
            @(negedge i_clk);
            for (k = 0; k < PHASE_REQS; k++)
                req_pending_q.push_back(rand_request());
            wait_idle();
        end

        $display("covered %0d requests under %0d tick step settings, %0d results checked",
                 req_accepted, N_PHASES + 1, results_seen);
        $display("mismatches: %0d", err_count);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
